FILE: src/pbpf_pkg.sv
// ----------------------------------------------------------------------------
// pbpf_pkg
// Shared types and constants for the polyline backtrack point filter.
// ----------------------------------------------------------------------------
package pbpf_pkg;

   localparam int FIELD_BITS = 32;

   typedef logic signed [FIELD_BITS-1:0] field_type;

   typedef struct packed {
      field_type x;
      field_type y;
      field_type z;
      logic      final_point;
   } point_type;

   typedef struct packed {
      logic fire;
      logic keep;
   } step_type;

endpackage

FILE: src/polyline_backtrack_point_filter.sv
// An accepted point waits in the input register until the result register is free,
// then moves there. Throughput: one point per cycle while the result side does not
// stall; the keep/drop decision and state update lie between the two registers.
// Dropped points produce no beat. Synchronous active-high reset empties both
// registers and clears the line state; the block accepts a point right after.
// ----------------------------------------------------------------------------
// polyline_backtrack_point_filter
// Streaming removal of repeated and backtracking interior polyline points.
// ----------------------------------------------------------------------------
module polyline_backtrack_point_filter #(
   parameter int COORD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pbpf_pkg::field_type    req_px,
   input  pbpf_pkg::field_type    req_py,
   input  pbpf_pkg::field_type    req_pz,
   input  logic                   req_final_point,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pbpf_pkg::field_type    rsp_qx,
   output pbpf_pkg::field_type    rsp_qy,
   output pbpf_pkg::field_type    rsp_qz,
   output logic                   rsp_end_of_line
);
   import pbpf_pkg::*;

   point_type req_point;
   point_type cur_point;
   point_type rsp_point;
   step_type  step;
   logic      fire;
   logic      out_free;

   assign req_point.x           = req_px;
   assign req_point.y           = req_py;
   assign req_point.z           = req_pz;
   assign req_point.final_point = req_final_point;

   assign rsp_qx          = rsp_point.x;
   assign rsp_qy          = rsp_point.y;
   assign rsp_qz          = rsp_point.z;
   assign rsp_end_of_line = rsp_point.final_point;

   pbpf_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_point (req_point),
      .out_free  (out_free),
      .fire      (fire),
      .cur_point (cur_point)
   );

   pbpf_decide #(
      .COORD_BITS (COORD_BITS)
   ) u_decide (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .cur_point (cur_point),
      .step      (step)
   );

   pbpf_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .cur_point (cur_point),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_point (rsp_point)
   );

endmodule

FILE: src/pbpf_in_stage.sv
// ----------------------------------------------------------------------------
// pbpf_in_stage
// Input register: holds one accepted point until the result side can advance.
// ----------------------------------------------------------------------------
module pbpf_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pbpf_pkg::point_type req_point,
   input  logic                out_free,
   output logic                fire,
   output pbpf_pkg::point_type cur_point
);
   import pbpf_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   point_type point_ff;
   logic      load;

   assign fire      = valid_ff && out_free;
   assign req_ready = !valid_ff || out_free;
   assign load      = req_valid && req_ready;
   assign valid_in  = load || (valid_ff && !fire);
   assign cur_point = point_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         point_ff <= req_point;
      end
   end

endmodule

FILE: src/pbpf_decide.sv
// ----------------------------------------------------------------------------
// pbpf_decide
// Keep/drop decision: repeat test and direction dot product against the last
// kept point and step, with the line state that tracks them.
// ----------------------------------------------------------------------------
module pbpf_decide #(
   parameter int COORD_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  pbpf_pkg::point_type cur_point,
   output pbpf_pkg::step_type  step
);
   import pbpf_pkg::*;

   localparam int DirBits  = COORD_BITS + 1;
   localparam int ProdBits = 2 * DirBits;
   localparam int SumBits  = ProdBits + 1;

   logic signed [COORD_BITS-1:0] cx;
   logic signed [COORD_BITS-1:0] cy;
   logic signed [COORD_BITS-1:0] kept_x_ff, kept_x_in;
   logic signed [COORD_BITS-1:0] kept_y_ff, kept_y_in;
   logic signed [DirBits-1:0]    dir_x_ff, dir_x_in;
   logic signed [DirBits-1:0]    dir_y_ff, dir_y_in;
   logic                         inside_ff, inside_in;
   logic signed [DirBits-1:0]    dx;
   logic signed [DirBits-1:0]    dy;
   logic signed [ProdBits-1:0]   prod_x;
   logic signed [ProdBits-1:0]   prod_y;
   logic signed [SumBits-1:0]    dot;
   logic                         last;
   logic                         same;
   logic                         has_dir;
   logic                         drop;

   generate
      if (COORD_BITS <= FIELD_BITS) begin : g_narrow
         assign cx = cur_point.x[COORD_BITS-1:0];
         assign cy = cur_point.y[COORD_BITS-1:0];
      end else begin : g_wide
         assign cx = {{(COORD_BITS-FIELD_BITS){cur_point.x[FIELD_BITS-1]}}, cur_point.x};
         assign cy = {{(COORD_BITS-FIELD_BITS){cur_point.y[FIELD_BITS-1]}}, cur_point.y};
      end
   endgenerate

   assign last    = cur_point.final_point;
   assign dx      = {cx[COORD_BITS-1], cx} - {kept_x_ff[COORD_BITS-1], kept_x_ff};
   assign dy      = {cy[COORD_BITS-1], cy} - {kept_y_ff[COORD_BITS-1], kept_y_ff};
   assign prod_x  = dir_x_ff * dx;
   assign prod_y  = dir_y_ff * dy;
   assign dot     = {prod_x[ProdBits-1], prod_x} + {prod_y[ProdBits-1], prod_y};
   assign same    = (cx == kept_x_ff) && (cy == kept_y_ff);
   assign has_dir = (dir_x_ff != '0) || (dir_y_ff != '0);
   assign drop    = inside_ff && !last && (same || (has_dir && dot[SumBits-1]));

   assign step.fire = fire;
   assign step.keep = !drop;

   always_comb begin
      kept_x_in = kept_x_ff;
      kept_y_in = kept_y_ff;
      dir_x_in  = dir_x_ff;
      dir_y_in  = dir_y_ff;
      inside_in = inside_ff;
      if (fire && last) begin
         kept_x_in = '0;
         kept_y_in = '0;
         dir_x_in  = '0;
         dir_y_in  = '0;
         inside_in = 1'b0;
      end else if (fire && !drop) begin
         kept_x_in = cx;
         kept_y_in = cy;
         inside_in = 1'b1;
         if (inside_ff) begin
            dir_x_in = dx;
            dir_y_in = dy;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_x_ff <= '0;
         kept_y_ff <= '0;
         dir_x_ff  <= '0;
         dir_y_ff  <= '0;
         inside_ff <= 1'b0;
      end else begin
         kept_x_ff <= kept_x_in;
         kept_y_ff <= kept_y_in;
         dir_x_ff  <= dir_x_in;
         dir_y_ff  <= dir_y_in;
         inside_ff <= inside_in;
      end
   end

endmodule

FILE: src/pbpf_out_stage.sv
// ----------------------------------------------------------------------------
// pbpf_out_stage
// Result register: captures each kept point and holds it until taken.
// ----------------------------------------------------------------------------
module pbpf_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  pbpf_pkg::step_type  step,
   input  pbpf_pkg::point_type cur_point,
   output logic                out_free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pbpf_pkg::point_type rsp_point
);
   import pbpf_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   point_type point_ff;
   logic      load;

   assign out_free  = !valid_ff || rsp_ready;
   assign load      = step.fire && step.keep;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_point = point_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         point_ff <= cur_point;
      end
   end

endmodule

FILE: src/pbpf_checker.sv
// ----------------------------------------------------------------------------
// pbpf_checker
// Port-level checks for the polyline backtrack point filter.
// ----------------------------------------------------------------------------
module pbpf_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input pbpf_pkg::field_type rsp_qx,
   input pbpf_pkg::field_type rsp_qy,
   input pbpf_pkg::field_type rsp_qz,
   input logic                rsp_end_of_line
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_qx) && $stable(rsp_qy)
         && $stable(rsp_qz) && $stable(rsp_end_of_line)))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("registers not empty after reset");

   a_rise_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result beat without an input beat two cycles before");

endmodule

bind polyline_backtrack_point_filter pbpf_checker u_pbpf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_qx          (rsp_qx),
   .rsp_qy          (rsp_qy),
   .rsp_qz          (rsp_qz),
   .rsp_end_of_line (rsp_end_of_line)
);

FILE: bench/pbpf_point_checker.sv
// ----------------------------------------------------------------------------
// pbpf_point_checker
// Watches both channels of the polyline point filter. Each accepted point
// runs through a local keep/drop model; kept points queue as expected beats
// and every result beat is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module pbpf_point_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  pbpf_pkg::field_type req_px,
   input  pbpf_pkg::field_type req_py,
   input  pbpf_pkg::field_type req_pz,
   input  logic                req_final_point,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  pbpf_pkg::field_type rsp_qx,
   input  pbpf_pkg::field_type rsp_qy,
   input  pbpf_pkg::field_type rsp_qz,
   input  logic                rsp_end_of_line,
   output int                  error_count,
   output int                  pending_count,
   output int                  kept_count,
   output int                  dropped_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import pbpf_pkg::*;

   typedef struct {
      field_type x;
      field_type y;
      field_type z;
      logic      eol;
   } kept_point_type;

   kept_point_type     kept_points_q[$];
   field_type          anchor_x;
   field_type          anchor_y;
   logic signed [32:0] heading_x;
   logic signed [32:0] heading_y;
   bit                 in_line;

   function automatic bit keep_point(field_type x, field_type y, logic last);
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [66:0] dot;
      bit                 keep;
      keep = 1'b1;
      if (in_line && !last) begin
         if (x == anchor_x && y == anchor_y) begin
            keep = 1'b0;
         end else begin
            dx = x - anchor_x;
            dy = y - anchor_y;
            dot = heading_x * dx + heading_y * dy;
            if ((heading_x != 0 || heading_y != 0) && dot < 0) begin
               keep = 1'b0;
            end else begin
               heading_x = dx;
               heading_y = dy;
            end
         end
      end
      if (keep) begin
         if (last) begin
            anchor_x = '0;
            anchor_y = '0;
            heading_x = '0;
            heading_y = '0;
            in_line = 1'b0;
         end else begin
            anchor_x = x;
            anchor_y = y;
            in_line = 1'b1;
         end
      end
      return keep;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      kept_point_type want;
      if (reset) begin
         anchor_x = '0;
         anchor_y = '0;
         heading_x = '0;
         heading_y = '0;
         in_line = 1'b0;
         kept_points_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (kept_points_q.size() == 0) begin
               $display("%0t: unexpected beat expected none got %h %h %h %b", $time,
                        rsp_qx, rsp_qy, rsp_qz, rsp_end_of_line);
               error_count++;
            end else begin
               want = kept_points_q.pop_front();
               check_field("qx", want.x, rsp_qx);
               check_field("qy", want.y, rsp_qy);
               check_field("qz", want.z, rsp_qz);
               check_field("end_of_line", {31'd0, want.eol}, {31'd0, rsp_end_of_line});
            end
         end
         if (req_valid && req_ready) begin
            if (keep_point(req_px, req_py, req_final_point)) begin
               want.x = req_px;
               want.y = req_py;
               want.z = req_pz;
               want.eol = req_final_point;
               kept_points_q.insert(kept_points_q.size(), want);
               kept_count++;
            end else begin
               dropped_count++;
            end
         end
      end
      pending_count = kept_points_q.size();
   end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives polylines into the point filter: a directed set of extremes, repeats,
// backtracks and short lines, then random lines with random idling on both
// sides and one long output stall. A checker beside the block scores beats.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pbpf_pkg::*;

   localparam int        CYCLE_LIMIT      = 200000;
   localparam int        POINT_TARGET     = 560;
   localparam int        QUIET_FROM       = 480;
   localparam int        HOLD_AT          = 200;
   localparam int        LONG_HOLD_CYCLES = 60;
   localparam int        DRAIN_CYCLES     = 8;
   localparam field_type COORD_MAX        = 32'sh7FFF_FFFF;
   localparam field_type COORD_MIN        = 32'sh8000_0000;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   field_type req_px = '0;
   field_type req_py = '0;
   field_type req_pz = '0;
   logic      req_final_point = 1'b0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   field_type rsp_qx;
   field_type rsp_qy;
   field_type rsp_qz;
   logic      rsp_end_of_line;

   int error_count;
   int pending_count;
   int kept_count;
   int dropped_count;
   int cycle_count;
   int points_sent;
   int lines_sent;
   bit sender_idle;
   bit receiver_idle;
   bit long_hold;

   polyline_backtrack_point_filter u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_px          (req_px),
      .req_py          (req_py),
      .req_pz          (req_pz),
      .req_final_point (req_final_point),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_qx          (rsp_qx),
      .rsp_qy          (rsp_qy),
      .rsp_qz          (rsp_qz),
      .rsp_end_of_line (rsp_end_of_line)
   );

   pbpf_point_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_px          (req_px),
      .req_py          (req_py),
      .req_pz          (req_pz),
      .req_final_point (req_final_point),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_qx          (rsp_qx),
      .rsp_qy          (rsp_qy),
      .rsp_qz          (rsp_qz),
      .rsp_end_of_line (rsp_end_of_line),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .kept_count      (kept_count),
      .dropped_count   (dropped_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
            rsp_ready <= 1'b1;
         end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_point(field_type x, field_type y, field_type z, logic last);
      if (sender_idle && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_px <= x;
      req_py <= y;
      req_pz <= z;
      req_final_point <= last;
      do @(posedge clock); while (!req_ready);
      points_sent++;
      if (last) lines_sent++;
   endtask

   function automatic field_type pick_extreme();
      field_type v;
      case ($urandom_range(0, 3))
         0: v = COORD_MAX;
         1: v = COORD_MIN;
         2: v = '0;
         default: v = -1;
      endcase
      return v;
   endfunction

   task automatic send_random_line();
      int        count;
      int        i;
      int        kind;
      field_type x;
      field_type y;
      field_type sx;
      field_type sy;
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
      if ($urandom_range(0, 3) == 0) begin
         x = $urandom;
         y = $urandom;
      end else begin
         x = int'($urandom_range(0, 2000)) - 1000;
         y = int'($urandom_range(0, 2000)) - 1000;
      end
      sx = '0;
      sy = '0;
      for (i = 0; i < count; i++) begin
         if (i > 0) begin
            kind = $urandom_range(0, 19);
            if (kind < 3) begin
               // repeat the previous point
            end else if (kind < 7) begin
               x = x - sx - (int'($urandom_range(0, 6)) - 3);
               y = y - sy - (int'($urandom_range(0, 6)) - 3);
            end else if (kind < 9) begin
               x = $urandom;
               y = $urandom;
            end else if (kind == 9) begin
               x = pick_extreme();
               y = pick_extreme();
            end else begin
               sx = int'($urandom_range(0, 100)) - 50;
               sy = int'($urandom_range(0, 100)) - 50;
               x = x + sx;
               y = y + sy;
            end
         end
         send_point(x, y, $urandom, i == count - 1);
      end
   endtask

   initial begin
      bit hold_done;
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
      hold_done = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // single point lines
      send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
      send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
      send_point('0, '0, '0, 1'b1);
      // two point line, last repeats first
      send_point('0, '0, -1, 1'b0);
      send_point('0, '0, 5, 1'b1);
      // full-range diagonal, then backtrack, repeat and reverse turn
      send_point(COORD_MIN, COORD_MIN, 1, 1'b0);
      send_point(COORD_MAX, COORD_MAX, 2, 1'b0);
      send_point(COORD_MIN, COORD_MIN, 3, 1'b0);
      send_point(COORD_MAX, COORD_MAX, 4, 1'b0);
      send_point(COORD_MAX, COORD_MIN, 5, 1'b0);
      send_point(COORD_MIN, COORD_MIN, 6, 1'b1);
      // right-angle turns, repeats, backtrack, repeated last point
      send_point('0, '0, 7, 1'b0);
      send_point('0, '0, 8, 1'b0);
      send_point(10, '0, 9, 1'b0);
      send_point(10, 10, 10, 1'b0);
      send_point(10, 10, 11, 1'b0);
      send_point(10, 5, 12, 1'b0);
      send_point(20, 10, 13, 1'b0);
      send_point(20, 10, 14, 1'b1);

      while (points_sent < POINT_TARGET) begin
         if (points_sent >= QUIET_FROM) begin
            sender_idle = 1'b0;
            receiver_idle = 1'b0;
         end else begin
            sender_idle = ($urandom_range(0, 4) != 0);
            receiver_idle = ($urandom_range(0, 4) != 0);
         end
         if (!hold_done && points_sent >= HOLD_AT) begin
            long_hold = 1'b1;
            hold_done = 1'b1;
         end
         send_random_line();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d points in %0d polylines, %0d kept, %0d dropped",
               points_sent, lines_sent, kept_count, dropped_count);
      $display("summary: extremes, repeats, backtracks, random idling, one long output stall");
      if (error_count == 0 && pending_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
